### rtl/dde_pkg.sv
// shared constants, types and twiddle tables of the direct dft engine
package dde_pkg;

   localparam int POINTS            = 64;
   localparam int TWIDDLE_FRAC_BITS = 15;

   localparam int SAMPLE_WIDTH = 16;
   localparam int OUT_WIDTH    = 23;
   localparam int BIN_WIDTH    = 6;
   localparam int IDX_WIDTH    = (POINTS > 2) ? $clog2(POINTS) : 1;
   localparam int TW_WIDTH     = TWIDDLE_FRAC_BITS + 1;
   localparam int PROD_WIDTH   = SAMPLE_WIDTH + TW_WIDTH;
   localparam int ACC_WIDTH    = SAMPLE_WIDTH + TW_WIDTH + 2 + IDX_WIDTH;

   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] im;
      logic signed [SAMPLE_WIDTH-1:0] re;
   } sample_type;

   typedef struct packed {
      logic                 valid;
      logic                 first;
      logic                 last;
      logic [BIN_WIDTH-1:0] bin;
      logic                 last_bin;
   } mac_ctrl_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_COMPUTE
   } state_type;

   typedef logic [POINTS-1:0][TW_WIDTH-1:0] tw_table_type;

   // sin(num/POINTS * pi/2), truncating series in q30, rounded to the twiddle precision
   function automatic logic [63:0] quarter_sine(input logic [63:0] num);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      x  = (num * HALF_PI_Q30) / POINTS;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd156);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
      s  = (x * t) >> 30;
      s  = (s + (64'd1 << (29 - TWIDDLE_FRAC_BITS))) >> (30 - TWIDDLE_FRAC_BITS);
      return s;
   endfunction

   function automatic logic [TW_WIDTH-1:0] tw_entry(input int m, input bit want_sin);
      int                 four;
      int                 r;
      logic [1:0]         qsel;
      logic signed [63:0] sm;
      logic signed [63:0] cm;
      logic signed [63:0] cv;
      logic signed [63:0] sv;
      logic signed [63:0] v;
      logic signed [63:0] top;
      four = 4 * m;
      qsel = 2'(four / POINTS);
      r    = four % POINTS;
      sm   = $signed(quarter_sine(64'(r)));
      cm   = $signed(quarter_sine(64'(POINTS - r)));
      case (qsel)
         2'd0: begin
            cv = cm;
            sv = sm;
         end
         2'd1: begin
            cv = -sm;
            sv = cm;
         end
         2'd2: begin
            cv = -cm;
            sv = -sm;
         end
         default: begin
            cv = sm;
            sv = -cm;
         end
      endcase
      top = (64'sd1 <<< TWIDDLE_FRAC_BITS) - 64'sd1;
      v   = want_sin ? sv : cv;
      if (v > top) begin
         v = top;
      end
      return TW_WIDTH'(v);
   endfunction

   function automatic tw_table_type build_table(input bit want_sin);
      tw_table_type tbl;
      int           i;
      for (i = 0; i < POINTS; i++) begin
         tbl[i] = tw_entry(i, want_sin);
      end
      return tbl;
   endfunction

   localparam tw_table_type TW_COS = build_table(1'b0);
   localparam tw_table_type TW_SIN = build_table(1'b1);

endpackage

### rtl/dde_sample_cell.sv
// one cell of the sample ring: holds a sample and passes it on when shifted
module dde_sample_cell (
   input  logic                clock,
   input  logic                shift,
   input  dde_pkg::sample_type d,
   output dde_pkg::sample_type q
);

   dde_pkg::sample_type sample_ff;
   dde_pkg::sample_type sample_in;

   always_comb begin
      sample_in = shift ? d : sample_ff;
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
   end

   assign q = sample_ff;

endmodule

### rtl/dde_mac.sv
// complex multiply-accumulate with rescale and saturation of each bin
module dde_mac (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dde_pkg::mac_ctrl_type                ctrl,
   input  dde_pkg::sample_type                  sample,
   input  logic signed [dde_pkg::TW_WIDTH-1:0]  tw_cos,
   input  logic signed [dde_pkg::TW_WIDTH-1:0]  tw_sin,
   output logic                                 out_strobe,
   output logic signed [dde_pkg::OUT_WIDTH-1:0] out_real,
   output logic signed [dde_pkg::OUT_WIDTH-1:0] out_imag,
   output logic [dde_pkg::BIN_WIDTH-1:0]        out_index,
   output logic                                 out_last
);

   localparam int PW = dde_pkg::PROD_WIDTH;
   localparam int AW = dde_pkg::ACC_WIDTH;
   localparam int FB = dde_pkg::TWIDDLE_FRAC_BITS;
   localparam logic signed [AW:0] SAT_HI = (AW+1)'(2 ** (dde_pkg::OUT_WIDTH - 1) - 1);
   localparam logic signed [AW:0] SAT_LO = (AW+1)'(-(2 ** (dde_pkg::OUT_WIDTH - 1)));
   localparam logic signed [AW:0] ROUND  = (AW+1)'(2 ** (FB - 1));

   dde_pkg::mac_ctrl_type ctrl1_ff, ctrl1_in;
   dde_pkg::mac_ctrl_type ctrl2_ff, ctrl2_in;

   logic signed [PW-1:0] p_rc_ff, p_rc_in;
   logic signed [PW-1:0] p_is_ff, p_is_in;
   logic signed [PW-1:0] p_ic_ff, p_ic_in;
   logic signed [PW-1:0] p_rs_ff, p_rs_in;

   logic signed [AW-1:0] acc_re_ff, acc_re_in;
   logic signed [AW-1:0] acc_im_ff, acc_im_in;
   logic signed [AW-1:0] base_re;
   logic signed [AW-1:0] base_im;

   logic                                 strobe_ff, strobe_in;
   logic signed [dde_pkg::OUT_WIDTH-1:0] real_ff, real_in;
   logic signed [dde_pkg::OUT_WIDTH-1:0] imag_ff, imag_in;
   logic [dde_pkg::BIN_WIDTH-1:0]        index_ff, index_in;
   logic                                 last_ff, last_in;

   function automatic logic signed [dde_pkg::OUT_WIDTH-1:0] rescale(
      input logic signed [AW-1:0] acc
   );
      logic signed [AW:0] v;
      v = ($signed({acc[AW-1], acc}) + ROUND) >>> FB;
      if (v > SAT_HI) begin
         v = SAT_HI;
      end else if (v < SAT_LO) begin
         v = SAT_LO;
      end
      return v[dde_pkg::OUT_WIDTH-1:0];
   endfunction

   // products
   always_comb begin
      ctrl1_in = ctrl;
      p_rc_in  = PW'(sample.re * tw_cos);
      p_is_in  = PW'(sample.im * tw_sin);
      p_ic_in  = PW'(sample.im * tw_cos);
      p_rs_in  = PW'(sample.re * tw_sin);
   end

   // accumulate, cleared on the first term of each bin
   always_comb begin
      ctrl2_in  = ctrl1_ff;
      base_re   = ctrl1_ff.first ? '0 : acc_re_ff;
      base_im   = ctrl1_ff.first ? '0 : acc_im_ff;
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      if (ctrl1_ff.valid) begin
         acc_re_in = base_re + AW'(p_rc_ff) + AW'(p_is_ff);
         acc_im_in = base_im + AW'(p_ic_ff) - AW'(p_rs_ff);
      end
   end

   // result beat
   always_comb begin
      strobe_in = ctrl2_ff.valid && ctrl2_ff.last;
      real_in   = real_ff;
      imag_in   = imag_ff;
      index_in  = index_ff;
      last_in   = last_ff;
      if (strobe_in) begin
         real_in  = rescale(acc_re_ff);
         imag_in  = rescale(acc_im_ff);
         index_in = ctrl2_ff.bin;
         last_in  = ctrl2_ff.last_bin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl1_ff  <= '0;
         ctrl2_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         ctrl1_ff  <= ctrl1_in;
         ctrl2_ff  <= ctrl2_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      p_rc_ff   <= p_rc_in;
      p_is_ff   <= p_is_in;
      p_ic_ff   <= p_ic_in;
      p_rs_ff   <= p_rs_in;
      acc_re_ff <= acc_re_in;
      acc_im_ff <= acc_im_in;
      real_ff   <= real_in;
      imag_ff   <= imag_in;
      index_ff  <= index_in;
      last_ff   <= last_in;
   end

   assign out_strobe = strobe_ff;
   assign out_real   = real_ff;
   assign out_imag   = imag_ff;
   assign out_index  = index_ff;
   assign out_last   = last_ff;

endmodule

### rtl/direct_dft_engine.sv
// top level of the direct dft engine: sample ring, sequencer and mac
//
// Usage: one complex sample is taken per beat on start/req_sample_*, accepted at a
// rising edge with start high and busy low. Samples fill a ring of POINTS cells in
// arrival order; a beat that does not complete a frame leaves busy low.
// The beat that completes a frame raises busy while the ring rotates once per bin
// past a single complex multiply-accumulate, one term a cycle; the twiddle index
// steps by k each cycle, modulo POINTS.
// Bin k appears on rsp_* for one cycle with rsp_strobe high; rsp_last_bin marks
// the final bin. Throughput is set by the one shared multiply-accumulate: samples
// of the next frame are not taken while busy is high.
// Loading of the next frame may start as soon as busy falls.
// The receiver cannot stall: every result beat is taken in its cycle.
// Reset (synchronous) empties the pipeline and restarts the frame at sample 0;
// sample contents are not cleared.
module direct_dft_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [dde_pkg::SAMPLE_WIDTH-1:0] req_sample_real,
   input  logic signed [dde_pkg::SAMPLE_WIDTH-1:0] req_sample_imag,
   output logic                                 rsp_strobe,
   output logic signed [dde_pkg::OUT_WIDTH-1:0] rsp_bin_real,
   output logic signed [dde_pkg::OUT_WIDTH-1:0] rsp_bin_imag,
   output logic [dde_pkg::BIN_WIDTH-1:0]        rsp_bin_index,
   output logic                                 rsp_last_bin
);

   localparam int N  = dde_pkg::POINTS;
   localparam int IW = dde_pkg::IDX_WIDTH;
   localparam logic [IW-1:0] IDX_LAST = IW'(N - 1);
   localparam logic [IW:0]   IDX_MOD  = (IW+1)'(N);

   dde_pkg::state_type state_ff, state_in;

   logic [IW-1:0] pos_ff, pos_in;
   logic [IW-1:0] k_ff, k_in;
   logic [IW-1:0] n_ff, n_in;
   logic [IW-1:0] m_ff, m_in;
   logic [IW:0]   m_sum;

   logic accept;
   logic frame_done;
   logic feed;
   logic n_last;
   logic k_last;
   logic shift;

   dde_pkg::sample_type   cell_q [N];
   dde_pkg::sample_type   tail_d;
   dde_pkg::sample_type   new_sample;
   dde_pkg::mac_ctrl_type ctrl;

   logic signed [dde_pkg::TW_WIDTH-1:0] tw_cos;
   logic signed [dde_pkg::TW_WIDTH-1:0] tw_sin;

   assign accept     = start && !busy;
   assign frame_done = accept && (pos_ff == IDX_LAST);
   assign n_last     = (n_ff == IDX_LAST);
   assign k_last     = (k_ff == IDX_LAST);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dde_pkg::ST_IDLE: begin
            if (frame_done) begin
               state_in = dde_pkg::ST_COMPUTE;
            end
         end
         dde_pkg::ST_COMPUTE: begin
            if (n_last && k_last) begin
               state_in = dde_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dde_pkg::ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      busy = 1'b0;
      feed = 1'b0;
      case (state_ff)
         dde_pkg::ST_IDLE: begin
            busy = 1'b0;
            feed = 1'b0;
         end
         dde_pkg::ST_COMPUTE: begin
            busy = 1'b1;
            feed = 1'b1;
         end
         default: begin
            busy = 1'b0;
            feed = 1'b0;
         end
      endcase
   end

   // counters
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         pos_in = (pos_ff == IDX_LAST) ? '0 : pos_ff + 1'b1;
      end
      m_sum = {1'b0, m_ff} + {1'b0, k_ff};
      k_in  = k_ff;
      n_in  = n_ff;
      m_in  = m_ff;
      if (feed) begin
         n_in = n_last ? '0 : n_ff + 1'b1;
         if (n_last) begin
            k_in = k_last ? '0 : k_ff + 1'b1;
            m_in = '0;
         end else if (m_sum >= IDX_MOD) begin
            m_in = IW'(m_sum - IDX_MOD);
         end else begin
            m_in = m_sum[IW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dde_pkg::ST_IDLE;
         pos_ff   <= '0;
         k_ff     <= '0;
         n_ff     <= '0;
         m_ff     <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         k_ff     <= k_in;
         n_ff     <= n_in;
         m_ff     <= m_in;
      end
   end

   // sample ring
   assign new_sample.re = req_sample_real;
   assign new_sample.im = req_sample_imag;
   assign tail_d        = feed ? cell_q[0] : new_sample;
   assign shift         = accept || feed;

   for (genvar i = 0; i < N; i++) begin : g_cell
      if (i == N - 1) begin : g_tail
         dde_sample_cell u_cell (
            .clock (clock),
            .shift (shift),
            .d     (tail_d),
            .q     (cell_q[i])
         );
      end else begin : g_body
         dde_sample_cell u_cell (
            .clock (clock),
            .shift (shift),
            .d     (cell_q[i+1]),
            .q     (cell_q[i])
         );
      end
   end

   assign tw_cos = $signed(dde_pkg::TW_COS[m_ff]);
   assign tw_sin = $signed(dde_pkg::TW_SIN[m_ff]);

   always_comb begin
      ctrl.valid    = feed;
      ctrl.first    = (n_ff == '0);
      ctrl.last     = n_last;
      ctrl.bin      = dde_pkg::BIN_WIDTH'(k_ff);
      ctrl.last_bin = k_last;
   end

   dde_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .sample     (cell_q[0]),
      .tw_cos     (tw_cos),
      .tw_sin     (tw_sin),
      .out_strobe (rsp_strobe),
      .out_real   (rsp_bin_real),
      .out_imag   (rsp_bin_imag),
      .out_index  (rsp_bin_index),
      .out_last   (rsp_last_bin)
   );

endmodule

### rtl/dde_checker.sv
// port-level checks of the direct dft engine, bound to the top level
module dde_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic                                 rsp_strobe,
   input logic [dde_pkg::BIN_WIDTH-1:0]        rsp_bin_index,
   input logic                                 rsp_last_bin
);

   localparam logic [dde_pkg::BIN_WIDTH-1:0] BIN_LAST =
      dde_pkg::BIN_WIDTH'(dde_pkg::POINTS - 1);

   // a frame is computed only after a beat was taken
   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without an accepted beat");

   // the last bin of a frame carries the top index
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_bin |-> rsp_bin_index == BIN_LAST)
      else $error("last bin flag on a wrong index");

   a_index_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_bin |-> rsp_bin_index != BIN_LAST)
      else $error("top bin without last bin flag");

   // result beats never come back to back
   a_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result beats back to back");

   // the first bin comes while a frame is being computed
   a_first_bin_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_bin_index == '0 |-> busy)
      else $error("first bin outside a frame computation");

endmodule

bind direct_dft_engine dde_checker u_dde_checker (.*);
